>>> design/arc_pkg.sv
// Package for the Art-Net receive classifier: codes, sizes and the result record.
// Used by every module of the design; depends on nothing.
`default_nettype none
package arc_pkg;
	localparam int MAX_PACKET_BYTES = 1024;
	localparam int PEER_SLOTS = 4;
	localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 2);
	localparam int PEER_IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
	localparam int DATA_START = 18;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [1:0] OP_NOP = 2'd3;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_SUMMARY = 2'd1;
	localparam logic [1:0] KIND_PEER = 2'd2;

	localparam logic [2:0] PT_IGNORED = 3'd0;
	localparam logic [2:0] PT_DMX = 3'd1;
	localparam logic [2:0] PT_POLL = 3'd2;
	localparam logic [2:0] PT_NZS = 3'd3;
	localparam logic [2:0] PT_ADDRESS = 3'd4;
	localparam logic [2:0] PT_IPPROG = 3'd5;
	localparam logic [2:0] PT_POLLREPLY = 3'd6;

	localparam logic [15:0] OPC_DMX = 16'h5000;
	localparam logic [15:0] OPC_POLL = 16'h2000;
	localparam logic [15:0] OPC_NZS = 16'h5100;
	localparam logic [15:0] OPC_ADDRESS = 16'h6000;
	localparam logic [15:0] OPC_IPPROG = 16'hF800;
	localparam logic [15:0] OPC_POLLREPLY = 16'h2100;

	localparam logic [7:0] IPPROG_CMD = 8'h84;
	localparam logic [7:0] LOW7_MASK = 8'h7F;
	localparam logic [7:0] BIT7_MASK = 8'h80;

	localparam logic [2:0] REG_UNIVERSE = 3'd0;
	localparam logic [2:0] REG_DMX_READ = 3'd1;
	localparam logic [2:0] REG_DMX_DELIVER = 3'd2;
	localparam logic [2:0] REG_POLL_REPLY = 3'd3;
	localparam logic [2:0] REG_NZS_ID = 3'd4;
	localparam logic [2:0] REG_PEER_EN = 3'd5;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] payload_byte;
		logic [9:0] payload_index;
		logic [2:0] packet_type;
		logic [15:0] universe;
		logic [15:0] data_length;
		logic [7:0] sequence_res;
		logic delivered;
		logic reply_directed;
		logic [31:0] address_value;
		logic [2:0] slot_written;
		logic is_last;
	} result_t;

	// Work handed from the front part to the peer table side.
	typedef struct packed {
		logic has_payload;
		result_t payload;
		logic has_summary;
		result_t summary;
		logic peer_write;
		logic peer_clear;
		logic peer_read;
		logic [1:0] slot;
		logic [31:0] sender;
	} job_t;

	function automatic logic [7:0] art_id(input logic [2:0] i);
		unique case (i)
			3'd0: art_id = 8'h41;
			3'd1: art_id = 8'h72;
			3'd2: art_id = 8'h74;
			3'd3: art_id = 8'h2D;
			3'd4: art_id = 8'h4E;
			3'd5: art_id = 8'h65;
			3'd6: art_id = 8'h74;
			default: art_id = 8'h00;
		endcase
	endfunction
endpackage
`default_nettype wire

>>> design/arc_front.sv
// Front part: parses packet bytes, keeps header state and forms payload and summary results.
// Depends on arc_pkg.
`default_nettype none
module arc_front
	import arc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic [1:0] op,
	input wire logic [7:0] data_byte,
	input wire logic last_byte,
	input wire logic [31:0] sender_ip,
	input wire logic [1:0] slot,
	input wire logic [14:0] port_universe,
	input wire logic dmx_read_enable,
	input wire logic dmx_deliver_enable,
	input wire logic poll_reply_enable,
	input wire logic [7:0] nzs_select_id,
	input wire logic peer_table_enable,
	output job_t job,
	output logic job_valid
);
	logic [CNT_W-1:0] byte_count_q;
	logic header_ok_q;
	logic [7:0] hdr_q [0:19];
	logic [7:0] addr_q [0:1];
	logic [31:0] sender_q;

	logic first;
	logic [CNT_W-1:0] pos, cnt_next;
	logic ok_n;
	logic [7:0] h [0:19];
	logic [7:0] a [0:1];
	logic [31:0] snd;
	logic [15:0] opc, uni;
	logic dmx_m, nzs_m, fwd, too_short;
	result_t pr, sr;

	assign pos = byte_count_q;
	assign first = (pos == '0);

	always_comb begin
		ok_n = first ? 1'b1 : header_ok_q;
		snd = first ? sender_ip : sender_q;
		for (int i = 0; i < 20; i++) begin
			h[i] = first ? 8'h00 : hdr_q[i];
			if (pos == CNT_W'(i)) h[i] = data_byte;
		end
		for (int i = 0; i < 2; i++) a[i] = first ? 8'h00 : addr_q[i];
		if (pos == CNT_W'(100)) a[0] = data_byte;
		if (pos == CNT_W'(104)) a[1] = data_byte;
		if (pos < CNT_W'(8) && data_byte != art_id(pos[2:0])) ok_n = 1'b0;
	end

	// The opcode value equals bytes 9 and 8 once byte 9 is seen, zero before.
	assign opc = (pos >= CNT_W'(9)) ? {h[9], h[8]} : 16'h0000;
	assign uni = {h[15], h[14]};
	assign dmx_m = ok_n && opc == OPC_DMX && dmx_read_enable && dmx_deliver_enable
		&& uni == {1'b0, port_universe};
	assign nzs_m = ok_n && opc == OPC_NZS && h[13] == nzs_select_id;
	assign fwd = pos >= CNT_W'(DATA_START) && pos < CNT_W'(MAX_PACKET_BYTES)
		&& (dmx_m || nzs_m);
	assign cnt_next = (pos <= CNT_W'(MAX_PACKET_BYTES)) ? pos + 1'b1 : pos;
	assign too_short = cnt_next < CNT_W'(7);

	always_comb begin
		pr = '0;
		pr.kind = KIND_PAYLOAD;
		pr.payload_byte = data_byte;
		pr.payload_index = 10'(pos - CNT_W'(DATA_START));
		pr.delivered = 1'b1;
		pr.is_last = !last_byte;
		sr = '0;
		sr.kind = KIND_SUMMARY;
		sr.is_last = 1'b1;
		if (!(cnt_next > CNT_W'(MAX_PACKET_BYTES) || !ok_n || too_short)) begin
			if ((opc == OPC_DMX && dmx_read_enable) || opc == OPC_NZS) begin
				sr.packet_type = (opc == OPC_DMX) ? PT_DMX : PT_NZS;
				sr.universe = uni;
				sr.data_length = {h[16], h[17]};
				sr.sequence_res = h[12];
				sr.delivered = (opc == OPC_DMX) ? dmx_m : nzs_m;
			end else if (opc == OPC_POLL && poll_reply_enable) begin
				sr.packet_type = PT_POLL;
				sr.reply_directed = snd[31:24] != 8'hFF;
			end else if (opc == OPC_ADDRESS) begin
				if ((a[0] & BIT7_MASK) != 8'h00) begin
					sr.packet_type = PT_ADDRESS;
					sr.universe = {1'b0, h[12][6:0], (a[1] << 4) | (a[0] & LOW7_MASK)};
				end
			end else if (opc == OPC_IPPROG) begin
				if (h[14] == IPPROG_CMD) begin
					sr.packet_type = PT_IPPROG;
					sr.address_value = {h[16], h[17], h[18], h[19]};
				end
			end else if (opc == OPC_POLLREPLY && peer_table_enable) begin
				sr.packet_type = PT_POLLREPLY;
			end
		end
	end

	always_comb begin
		job = '0;
		job.slot = slot;
		job.sender = snd;
		job.payload = pr;
		job.summary = sr;
		job_valid = 1'b0;
		if (in_valid) begin
			unique case (op)
				OP_BYTE: begin
					job.has_payload = fwd;
					job.has_summary = last_byte;
					job.peer_write = last_byte && sr.packet_type == PT_POLLREPLY;
					job_valid = fwd || last_byte;
				end
				OP_CLEAR: begin
					job.peer_clear = 1'b1;
					job_valid = 1'b1;
				end
				OP_READ: begin
					job.peer_read = 1'b1;
					job_valid = 1'b1;
				end
				default: job_valid = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			header_ok_q <= 1'b1;
			sender_q <= '0;
			for (int i = 0; i < 20; i++) hdr_q[i] <= '0;
			addr_q[0] <= '0;
			addr_q[1] <= '0;
		end else if (in_valid && op == OP_BYTE) begin
			byte_count_q <= last_byte ? '0 : cnt_next;
			header_ok_q <= ok_n;
			sender_q <= snd;
			for (int i = 0; i < 20; i++) hdr_q[i] <= h[i];
			addr_q[0] <= a[0];
			addr_q[1] <= a[1];
		end
	end
endmodule
`default_nettype wire

>>> design/arc_queue.sv
// Short queue of jobs between the front and back parts.
// Depends on arc_pkg.
`default_nettype none
module arc_queue
	import arc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire job_t push_job,
	output logic full,
	input wire logic pop,
	output job_t pop_job,
	output logic empty
);
	localparam int AW = $clog2(QUEUE_DEPTH);
	job_t mem_q [0:QUEUE_DEPTH-1];
	logic [AW:0] wr_q, rd_q;

	assign empty = wr_q == rd_q;
	assign full = (wr_q[AW] != rd_q[AW]) && (wr_q[AW-1:0] == rd_q[AW-1:0]);
	assign pop_job = mem_q[rd_q[AW-1:0]];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q[AW-1:0]] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
		end
	end
endmodule
`default_nettype wire

>>> design/arc_back.sv
// Back part: peer table updates and reads, and emission of up to two results per job.
// Depends on arc_pkg.
`default_nettype none
module arc_back
	import arc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic job_valid,
	input wire job_t job,
	output logic job_pop,
	output logic out_valid,
	input wire logic out_ready,
	output result_t out_res
);
	logic [31:0] peer_q [0:PEER_SLOTS-1];
	logic half_q;
	logic valid_q;
	result_t res_q;

	logic dup;
	logic found;
	logic [PEER_IDX_W-1:0] empty_idx;
	logic load, second;
	result_t nxt;

	always_comb begin
		dup = 1'b0;
		found = 1'b0;
		empty_idx = '0;
		for (int i = 0; i < PEER_SLOTS; i++) begin
			if (peer_q[i] == job.sender) dup = 1'b1;
			if (peer_q[i] == 32'h0 && !dup) begin
				found = 1'b1;
				empty_idx = PEER_IDX_W'(i);
			end
		end
	end

	assign second = job.has_payload && job.has_summary && !half_q;
	assign load = job_valid && (!valid_q || out_ready);
	assign job_pop = load && !second && !job.peer_clear;

	always_comb begin
		nxt = '0;
		if (job.has_payload && !half_q) nxt = job.payload;
		else if (job.has_summary) begin
			nxt = job.summary;
			if (job.peer_write && !dup && found && job.sender != 32'h0)
				nxt.slot_written = 3'(empty_idx) + 3'd1;
		end else begin
			nxt.kind = KIND_PEER;
			nxt.is_last = 1'b1;
			if (32'(job.slot) < 32'(PEER_SLOTS))
				nxt.address_value = peer_q[PEER_IDX_W'(job.slot)];
		end
	end

	assign out_valid = valid_q;
	assign out_res = res_q;

	always_ff @(posedge clk) begin
		if (load) res_q <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q <= 1'b0;
			for (int i = 0; i < PEER_SLOTS; i++) peer_q[i] <= '0;
		end else begin
			if (out_ready || !valid_q) valid_q <= load && !job.peer_clear;
			if (load) half_q <= second;
			if (load && job.peer_clear) begin
				if (32'(job.slot) < 32'(PEER_SLOTS)) peer_q[PEER_IDX_W'(job.slot)] <= '0;
			end
			if (load && job.peer_write && job.has_summary && !second && !dup && found
				&& job.sender != 32'h0)
				peer_q[empty_idx] <= job.sender;
		end
	end
endmodule
`default_nettype wire

>>> design/artnet_receive_classifier_core.sv
// Top level of the Art-Net receive classifier.
// Depends on arc_pkg, arc_front, arc_queue and arc_back.
//
// Input stream s_axis: one transaction per item, one byte per cycle, taken while the
// job queue has room. tuser carries op and slot, tlast marks the last packet byte.
// Output stream m_axis carries payload bytes, packet summaries and peer slot reads.
// A packet byte that produces a result reaches m_axis through a four-entry queue
// and an output register.
// Throughput is one item per cycle while the receiver takes results; a final byte that also
// forwards data produces two results, the payload byte first and then the summary.
// When the receiver stalls, the queue fills and s_axis_tready falls after four jobs.
// Clearing a peer slot produces no result; it leaves the queue once the output register is free.
// Reset clears the parser, the queue, the peer table, the configuration and the output valid flag.
// Configuration writes take effect at the next edge; write only while the block is idle.
`default_nettype none
module artnet_receive_classifier_core
	import arc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [39:0] s_axis_tdata, // data_byte[7:0], sender_ip[39:8]
	input wire logic s_axis_tlast,
	input wire logic [3:0] s_axis_tuser, // op[1:0], slot[3:2]
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [95:0] m_axis_tdata, // payload_byte, payload_index, universe,
	// data_length, sequence_res, delivered, reply_directed, address_value, slot_written
	output logic m_axis_tlast, // is_last
	output logic [4:0] m_axis_tuser, // kind[1:0], packet_type[4:2]
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [14:0] cfg_data
);
	logic [14:0] port_universe_q;
	logic dmx_read_q, dmx_deliver_q, poll_reply_q, peer_en_q;
	logic [7:0] nzs_id_q;
	job_t fj, qj;
	logic fj_valid, full, empty, pop;
	result_t r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_universe_q <= '0;
			dmx_read_q <= 1'b0;
			dmx_deliver_q <= 1'b0;
			poll_reply_q <= 1'b0;
			nzs_id_q <= '0;
			peer_en_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_UNIVERSE: port_universe_q <= cfg_data;
				REG_DMX_READ: dmx_read_q <= cfg_data[0];
				REG_DMX_DELIVER: dmx_deliver_q <= cfg_data[0];
				REG_POLL_REPLY: poll_reply_q <= cfg_data[0];
				REG_NZS_ID: nzs_id_q <= cfg_data[7:0];
				REG_PEER_EN: peer_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = !full;

	arc_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid && !full),
		.op(s_axis_tuser[1:0]),
		.data_byte(s_axis_tdata[7:0]),
		.last_byte(s_axis_tlast),
		.sender_ip(s_axis_tdata[39:8]),
		.slot(s_axis_tuser[3:2]),
		.port_universe(port_universe_q),
		.dmx_read_enable(dmx_read_q),
		.dmx_deliver_enable(dmx_deliver_q),
		.poll_reply_enable(poll_reply_q),
		.nzs_select_id(nzs_id_q),
		.peer_table_enable(peer_en_q),
		.job(fj),
		.job_valid(fj_valid)
	);

	arc_queue u_queue (
		.clk, .arst_n,
		.push(fj_valid),
		.push_job(fj),
		.full,
		.pop(pop || (!empty && qj.peer_clear && (!m_axis_tvalid || m_axis_tready))),
		.pop_job(qj),
		.empty
	);

	arc_back u_back (
		.clk, .arst_n,
		.job_valid(!empty),
		.job(qj),
		.job_pop(pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res(r)
	);

	assign m_axis_tdata = {1'b0, r.slot_written, r.address_value, r.reply_directed,
		r.delivered, r.sequence_res, r.data_length, r.universe, r.payload_index,
		r.payload_byte};
	assign m_axis_tlast = r.is_last;
	assign m_axis_tuser = {r.packet_type, r.kind};
endmodule
`default_nettype wire

>>> design/arc_checker.sv
// Port-level checker for the Art-Net receive classifier, bound to the top level.
// Depends on arc_pkg for the result kind codes.
`default_nettype none
module arc_checker
	import arc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [95:0] m_axis_tdata,
	input wire logic m_axis_tlast,
	input wire logic [4:0] m_axis_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");
	a_peer_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1:0] == KIND_PEER |-> m_axis_tlast)
		else $error("peer read not last");
	a_sum_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1:0] == KIND_SUMMARY |-> m_axis_tlast)
		else $error("summary not last");
	a_payload_deliv: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1:0] == KIND_PAYLOAD |-> m_axis_tdata[58])
		else $error("payload without delivered flag");
endmodule

bind artnet_receive_classifier_core arc_checker u_arc_checker (.*);
`default_nettype wire
